// ===== hw/rtl/mmsh_pkg.sv =====
`default_nettype none

package mmsh_pkg;

	// midi status values
	localparam logic [7:0] STATUS_SYS   = 8'hF0;
	localparam logic [3:0] MSG_NOTE     = 4'h9;
	localparam logic [3:0] MSG_CC       = 4'hB;
	localparam logic [3:0] MSG_PROGRAM  = 4'hC;
	localparam logic [3:0] MSG_PRESSURE = 4'hD;

	// controller and note codes
	localparam logic [6:0] SLIDER_LO_FIRST = 7'h10;
	localparam logic [6:0] SLIDER_LO_LAST  = 7'h1F;
	localparam logic [6:0] SLIDER_HI_FIRST = 7'h2E;
	localparam logic [6:0] SLIDER_HI_LAST  = 7'h3E;
	localparam logic [6:0] SLIDER_HI_BIAS  = 7'd30;
	localparam logic [6:0] NOTE_RESET      = 7'h19;
	localparam logic [6:0] NOTE_FIRST      = 7'h01;

	localparam logic [5:0] NO_CHAIN = 6'h3F;

	typedef enum logic [1:0] {
		RES_LED    = 2'd0,
		RES_SLIDER = 2'd1,
		RES_RESET  = 2'd2
	} res_kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ECHO_ALL,
		ST_RADIO
	} state_t;

	// complete message handed from the parser
	typedef struct packed {
		logic       fire;
		logic [3:0] kind;
		logic [6:0] code;
		logic [6:0] value;
	} msg_t;

	typedef struct packed {
		res_kind_t  kind;
		logic [4:0] led_code;
		logic       led_lit;
		logic [3:0] col;
		logic [1:0] row;
		logic [6:0] level;
		logic       last;
	} res_t;

	// x / 3 for x below 24 by reciprocal multiply
	function automatic logic [2:0] div3(input logic [4:0] x);
		logic [8:0] p;
		begin
			p = {4'd0, x} * 9'd11;
			div3 = p[7:5];
		end
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/mmsh_parser.sv =====
`default_nettype none

module mmsh_parser (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           take,
	input  wire logic [7:0]     rx_byte,
	output mmsh_pkg::msg_t      msg
);

	logic [3:0] kind_q;
	logic       kind_vld_q;
	logic [6:0] first_q;
	logic       first_vld_q;
	logic       is_sys;
	logic       is_status;
	logic       drop_now;

	always_comb begin
		is_sys    = rx_byte >= mmsh_pkg::STATUS_SYS;
		is_status = rx_byte[7];
		// program change and channel pressure are dropped on arrival
		drop_now  = (rx_byte[7:4] == mmsh_pkg::MSG_PROGRAM) ||
			(rx_byte[7:4] == mmsh_pkg::MSG_PRESSURE);
		msg.fire  = take && !is_status && kind_vld_q && first_vld_q;
		msg.kind  = kind_q;
		msg.code  = first_q;
		msg.value = rx_byte[6:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_vld_q  <= 1'b0;
			first_vld_q <= 1'b0;
		end else if (take) begin
			if (is_sys) begin
				kind_vld_q  <= 1'b0;
				first_vld_q <= 1'b0;
			end else if (is_status) begin
				kind_vld_q <= !drop_now;
				if (drop_now) begin
					first_vld_q <= 1'b0;
				end
			end else if (kind_vld_q) begin
				if (first_vld_q) begin
					// message complete, no running status
					kind_vld_q  <= 1'b0;
					first_vld_q <= 1'b0;
				end else begin
					first_vld_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && is_status) begin
			kind_q <= rx_byte[7:4];
		end
		if (take && !is_status && !first_vld_q) begin
			first_q <= rx_byte[6:0];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/midi_mixer_surface_handler.sv =====
`default_nettype none

// Mixer surface handler: takes received midi bytes one transaction at a time
// and answers with slider updates, button led echoes and slider reset
// requests, each result marked last on the final one a byte causes. A byte
// that completes no message is taken and gives nothing. A byte that
// completes a message moves to a decode state that waits for a free
// output register and gives a slider update, toggle or reset there; a
// solo move then sweeps the columns and the send-all sync at code 0x3E
// sweeps all buttons. Both sweeps use a single index counter, one result
// per cycle into the output register while it is free, skipping columns
// with no change; in_ready is low until the block is idle again, after the
// last result of the byte and any sweep. A stall on the output side holds
// the counter. Button state is all off after reset with no clearing pass.
module midi_mixer_surface_handler #(
	parameter int COLUMNS = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      kind,
	output logic [4:0]      led_code,
	output logic            led_lit,
	output logic [3:0]      slider_column,
	output logic [1:0]      slider_row,
	output logic [6:0]      slider_level,
	output logic            last
);

	// button count, index width and column counter width
	localparam int NB = 3 * COLUMNS;
	localparam int IW = $clog2(NB);
	localparam int CW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	mmsh_pkg::state_t state_q, state_d;
	mmsh_pkg::msg_t   msg;
	mmsh_pkg::msg_t   msg_q;
	mmsh_pkg::res_t   res_q, res_d;

	logic           out_valid_q;
	logic           out_free;
	logic           accept;
	logic [NB-1:0]  btn_q, btn_d;
	logic           btn_ld;
	logic [5:0]     chain_q, chain_d;
	logic           chain_ld;
	logic [IW-1:0]  cnt_q;
	logic           cnt_clr;
	logic           cnt_inc;
	logic [COLUMNS-1:0] chg_q, chg_d;
	logic           chg_ld;
	logic           emit;

	// decode of the held message
	logic           is_cc, is_note;
	logic           lo_hit, hi_hit, slider_hit;
	logic [5:0]     pos;
	logic [5:0]     want;
	logic           chain_match;
	logic           sync;
	logic           btn_hit;
	logic [4:0]     bidx;
	logic [2:0]     bcol;
	logic [4:0]     brow_full;
	logic           is_solo;
	logic [COLUMNS-1:0] solo;
	logic [COLUMNS-1:0] radio_solo;
	logic [COLUMNS-1:0] sync_solo;
	logic [CW-1:0]  high_col;

	// radio scan helpers
	logic [CW-1:0]  col_cnt;
	logic [IW-1:0]  ridx;
	logic           more_chg;
	logic           radio_adv;

	mmsh_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (accept),
		.rx_byte (rx_byte),
		.msg     (msg)
	);

	assign in_ready = (state_q == mmsh_pkg::ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign out_valid     = out_valid_q;
	assign kind          = res_q.kind;
	assign led_code      = res_q.led_code;
	assign led_lit       = res_q.led_lit;
	assign slider_column = res_q.col;
	assign slider_row    = res_q.row;
	assign slider_level  = res_q.level;
	assign last          = res_q.last;

	// message decode
	always_comb begin
		is_cc   = (msg_q.kind == mmsh_pkg::MSG_CC);
		is_note = (msg_q.kind == mmsh_pkg::MSG_NOTE);
		lo_hit  = (msg_q.code >= mmsh_pkg::SLIDER_LO_FIRST) &&
			(msg_q.code <= mmsh_pkg::SLIDER_LO_LAST);
		hi_hit  = (msg_q.code >= mmsh_pkg::SLIDER_HI_FIRST) &&
			(msg_q.code <= mmsh_pkg::SLIDER_HI_LAST);
		slider_hit = lo_hit || hi_hit;
		// chain position: low bank 0..15, high bank 16..32
		if (lo_hit) begin
			pos = {2'd0, msg_q.code[3:0]};
		end else begin
			pos = 6'(msg_q.code - mmsh_pkg::SLIDER_HI_BIAS);
		end
		want        = (pos == 6'd0) ? mmsh_pkg::NO_CHAIN : pos - 6'd1;
		chain_match = (chain_q == want);
		sync        = chain_match && (msg_q.code == mmsh_pkg::SLIDER_HI_LAST);

		btn_hit   = (msg_q.code >= mmsh_pkg::NOTE_FIRST) && (msg_q.code <= 7'(NB));
		bidx      = 5'(msg_q.code) - 5'd1;
		bcol      = mmsh_pkg::div3(bidx);
		brow_full = bidx - 5'({bcol, 1'b0}) - 5'(bcol);
		is_solo   = (brow_full == 5'd1);
	end

	// solo bits, radio target and sync winner
	always_comb begin
		high_col = '0;
		for (int c = 0; c < COLUMNS; c++) begin
			solo[c]       = btn_q[c * 3 + 1];
			radio_solo[c] = (c == int'(bcol));
			if (btn_q[c * 3 + 1]) begin
				high_col = CW'(c);
			end
		end
		for (int c = 0; c < COLUMNS; c++) begin
			sync_solo[c] = (c == int'(high_col));
		end
		chg_d = solo ^ radio_solo;
	end

	// radio scan over columns
	always_comb begin
		col_cnt  = cnt_q[CW-1:0];
		ridx     = IW'({col_cnt, 1'b0}) + IW'(col_cnt) + IW'(1);
		more_chg = 1'b0;
		for (int c = 0; c < COLUMNS; c++) begin
			if ((c > int'(col_cnt)) && chg_q[c]) begin
				more_chg = 1'b1;
			end
		end
		radio_adv = !chg_q[col_cnt] || out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mmsh_pkg::ST_IDLE: begin
				if (accept && msg.fire) begin
					state_d = mmsh_pkg::ST_DECODE;
				end
			end
			mmsh_pkg::ST_DECODE: begin
				if (out_free) begin
					if (is_cc && slider_hit && sync) begin
						state_d = mmsh_pkg::ST_ECHO_ALL;
					end else if (is_note && btn_hit && is_solo && (chg_d != '0)) begin
						state_d = mmsh_pkg::ST_RADIO;
					end else begin
						state_d = mmsh_pkg::ST_IDLE;
					end
				end
			end
			mmsh_pkg::ST_ECHO_ALL: begin
				if (out_free && (cnt_q == IW'(NB - 1))) begin
					state_d = mmsh_pkg::ST_IDLE;
				end
			end
			mmsh_pkg::ST_RADIO: begin
				if (radio_adv && (col_cnt == CW'(COLUMNS - 1))) begin
					state_d = mmsh_pkg::ST_IDLE;
				end
			end
			default: state_d = mmsh_pkg::ST_IDLE;
		endcase
	end

	// result generation and state updates
	always_comb begin
		emit     = 1'b0;
		res_d    = '0;
		btn_d    = btn_q;
		btn_ld   = 1'b0;
		chain_d  = mmsh_pkg::NO_CHAIN;
		chain_ld = 1'b0;
		cnt_clr  = 1'b0;
		cnt_inc  = 1'b0;
		chg_ld   = 1'b0;
		case (state_q)
			mmsh_pkg::ST_DECODE: begin
				if (out_free) begin
					if (is_cc && slider_hit) begin
						emit       = 1'b1;
						res_d.kind = mmsh_pkg::RES_SLIDER;
						// upper bank column is pos / 4 as well, master lands on 8
						res_d.col   = pos[5:2];
						res_d.row   = pos[1:0];
						res_d.level = msg_q.value;
						res_d.last  = !sync;
						chain_ld    = 1'b1;
						if (chain_match && !sync) begin
							chain_d = pos;
						end
						if (sync) begin
							for (int c = 0; c < COLUMNS; c++) begin
								btn_d[c * 3 + 1] = sync_solo[c];
							end
							btn_ld  = 1'b1;
							cnt_clr = 1'b1;
						end
					end else if (is_note && btn_hit) begin
						if (is_solo) begin
							for (int c = 0; c < COLUMNS; c++) begin
								btn_d[c * 3 + 1] = radio_solo[c];
							end
							btn_ld  = 1'b1;
							chg_ld  = 1'b1;
							cnt_clr = 1'b1;
						end else begin
							// mute or rec toggle
							btn_d[bidx[IW-1:0]] = !btn_q[bidx[IW-1:0]];
							btn_ld         = 1'b1;
							emit           = 1'b1;
							res_d.kind     = mmsh_pkg::RES_LED;
							res_d.led_code = bidx + 5'd1;
							res_d.led_lit  = !btn_q[bidx[IW-1:0]];
							res_d.last     = 1'b1;
						end
					end else if (is_note && (msg_q.code == mmsh_pkg::NOTE_RESET)) begin
						emit       = 1'b1;
						res_d.kind = mmsh_pkg::RES_RESET;
						res_d.last = 1'b1;
					end
				end
			end
			mmsh_pkg::ST_ECHO_ALL: begin
				if (out_free) begin
					emit           = 1'b1;
					res_d.kind     = mmsh_pkg::RES_LED;
					res_d.led_code = 5'(cnt_q) + 5'd1;
					res_d.led_lit  = btn_q[cnt_q];
					res_d.last     = (cnt_q == IW'(NB - 1));
					cnt_inc        = 1'b1;
				end
			end
			mmsh_pkg::ST_RADIO: begin
				cnt_inc = radio_adv;
				if (chg_q[col_cnt] && out_free) begin
					emit           = 1'b1;
					res_d.kind     = mmsh_pkg::RES_LED;
					res_d.led_code = 5'(ridx) + 5'd1;
					res_d.led_lit  = btn_q[ridx];
					res_d.last     = !more_chg;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mmsh_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			btn_q       <= '0;
			chain_q     <= mmsh_pkg::NO_CHAIN;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (btn_ld) begin
				btn_q <= btn_d;
			end
			if (chain_ld) begin
				chain_q <= chain_d;
			end
			if (cnt_clr) begin
				cnt_q <= '0;
			end else if (cnt_inc) begin
				cnt_q <= cnt_q + IW'(1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && msg.fire) begin
			msg_q <= msg;
		end
		if (emit) begin
			res_q <= res_d;
		end
		if (chg_ld) begin
			chg_q <= chg_d;
		end
	end

	// at most one solo button is ever lit
	assert property (@(posedge clk) disable iff (!arst_n) $onehot0(solo))
		else $error("more than one solo button lit");

	// the sync echo run always reports exactly one solo on
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && (state_q == mmsh_pkg::ST_ECHO_ALL)) |-> $onehot(solo))
		else $error("sync echo without a single solo");

	// the final result of a byte hands control back to the input side,
	// the radio scan finishes its column sweep first
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit && res_d.last && (state_q != mmsh_pkg::ST_RADIO))
		|=> (state_q == mmsh_pkg::ST_IDLE))
		else $error("sequencer busy after last result");

	// a chain never holds the master position or an unused code
	assert property (@(posedge clk) disable iff (!arst_n)
		(chain_q == mmsh_pkg::NO_CHAIN) || (chain_q < 6'd32))
		else $error("chain position out of range");

endmodule

`default_nettype wire

// ===== verif/tb_midi_mixer_surface_handler.sv =====
`default_nettype none

module tb_midi_mixer_surface_handler;

	localparam int SURFACE_COLUMNS = 8;
	localparam int SURFACE_BUTTONS = 3 * SURFACE_COLUMNS;
	localparam int CLK_PERIOD      = 12;
	localparam int HOLD_CYCLES     = 600;
	localparam int ITEM_TARGET     = 220;
	localparam int DRAIN_CYCLES    = 64;
	localparam logic [7:0] ASM_EMPTY = 8'hFF;

	// statuses the surface drops
	localparam logic [3:0] MSG_NOTE_OFF      = 4'h8;
	localparam logic [3:0] MSG_POLY_PRESSURE = 4'hA;
	localparam logic [3:0] MSG_PITCH_BEND    = 4'hE;

	// clock and reset, reset held from time zero
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	// block inputs, known from the start
	logic       in_valid  = 1'b0;
	logic [7:0] rx_byte   = 8'h00;
	logic       out_ready = 1'b0;

	// block outputs
	logic       in_ready;
	logic       out_valid;
	logic [1:0] kind;
	logic [4:0] led_code;
	logic       led_lit;
	logic [3:0] slider_column;
	logic [1:0] slider_row;
	logic [6:0] slider_level;
	logic       last;

	midi_mixer_surface_handler #(
		.COLUMNS(SURFACE_COLUMNS)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.led_code     (led_code),
		.led_lit      (led_lit),
		.slider_column(slider_column),
		.slider_row   (slider_row),
		.slider_level (slider_level),
		.last         (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// bytes waiting to be offered, and surface results still to arrive
	logic [7:0]      pending_bytes[$];
	mmsh_pkg::res_t  expected_results[$];
	mmsh_pkg::res_t  next_result;

	int n_total    = 0;
	int n_accepted = 0;
	int n_results  = 0;
	int err_count  = 0;

	// idle shaping for both sides
	int src_gap   = 0;
	int src_calm  = 0;
	int sink_gap  = 0;
	int sink_calm = 0;

	// long receiver hold-off
	logic       sink_hold  = 1'b0;
	int         hold_left  = 0;
	logic [1:0] holds_done = 2'd0;

	// shadow of the surface: message under assembly, buttons, send-all chain
	logic [7:0]                 asm_kind;
	logic [7:0]                 asm_chan;
	logic [7:0]                 asm_first;
	logic [7:0]                 asm_second;
	logic [SURFACE_BUTTONS-1:0] btn_lit;
	logic [5:0]                 chain_at;

	task automatic report_mismatch(input string what);
		$display("mismatch at result %0d: %s", n_results, what);
		err_count++;
	endtask

	// wait cycles before the next transaction, with runs of back-to-back ones
	function automatic int pick_gap(inout int calm);
		if (calm > 0) begin
			calm = calm - 1;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	task automatic clear_assembly();
		asm_kind   = ASM_EMPTY;
		asm_chan   = ASM_EMPTY;
		asm_first  = ASM_EMPTY;
		asm_second = ASM_EMPTY;
	endtask

	task automatic queue_result(input mmsh_pkg::res_kind_t k, input int code,
			input bit lit, input int col, input int row, input int level);
		mmsh_pkg::res_t r;
		r.kind     = k;
		r.led_code = code[4:0];
		r.led_lit  = lit;
		r.col      = col[3:0];
		r.row      = row[1:0];
		r.level    = level[6:0];
		r.last     = 1'b0;
		expected_results.push_back(r);
	endtask

	task automatic queue_led(input int idx);
		queue_result(mmsh_pkg::RES_LED, idx + 1, btn_lit[idx], 0, 0, 0);
	endtask

	// surface results caused by one accepted byte
	task automatic predict_byte(input logic [7:0] b);
		int             base;
		int             code;
		int             val;
		int             p;
		int             col;
		int             row;
		int             prev;
		int             want;
		int             solo;
		mmsh_pkg::res_t tail;
		base = expected_results.size();
		// system bytes drop whatever is half assembled
		if (b >= mmsh_pkg::STATUS_SYS) begin
			clear_assembly();
			return;
		end
		if (b[7]) begin
			asm_kind = {4'h0, b[7:4]};
			asm_chan = {4'h0, b[3:0]};
		end else if (asm_kind == ASM_EMPTY) begin
			// data with no status held
			return;
		end else if (asm_first == ASM_EMPTY) begin
			asm_first = b;
		end else begin
			asm_second = b;
		end

		if (asm_kind != ASM_EMPTY && asm_chan != ASM_EMPTY &&
				(asm_kind == mmsh_pkg::MSG_PROGRAM || asm_kind == mmsh_pkg::MSG_PRESSURE ||
				asm_second != ASM_EMPTY)) begin
			code = asm_first;
			val  = asm_second;
			if (asm_kind == mmsh_pkg::MSG_CC) begin
				p = -1;
				if (code >= mmsh_pkg::SLIDER_LO_FIRST && code <= mmsh_pkg::SLIDER_LO_LAST)
					p = code - mmsh_pkg::SLIDER_LO_FIRST;
				else if (code >= mmsh_pkg::SLIDER_HI_FIRST &&
						code <= mmsh_pkg::SLIDER_HI_LAST)
					p = code - mmsh_pkg::SLIDER_HI_FIRST + 16;
				if (p >= 0) begin
					col  = (p < 16) ? p / 4 : 4 + (p - 16) / 4;
					row  = (p < 16) ? p % 4 : (p - 16) % 4;
					prev = chain_at;
					want = (p == 0) ? mmsh_pkg::NO_CHAIN : p - 1;
					queue_result(mmsh_pkg::RES_SLIDER, 0, 1'b0, col, row, val);
					chain_at = mmsh_pkg::NO_CHAIN;
					if (prev == want) begin
						if (code == mmsh_pkg::SLIDER_HI_LAST) begin
							// send-all sync: one solo on, highest column wins
							solo = 0;
							for (int c = 0; c < SURFACE_COLUMNS; c++)
								if (btn_lit[c * 3 + 1])
									solo = c;
							for (int c = 0; c < SURFACE_COLUMNS; c++)
								btn_lit[c * 3 + 1] = (c == solo);
							for (int i = 0; i < SURFACE_BUTTONS; i++)
								queue_led(i);
						end else begin
							chain_at = p[5:0];
						end
					end
				end
			end else if (asm_kind == mmsh_pkg::MSG_NOTE) begin
				if (code >= mmsh_pkg::NOTE_FIRST && code <= SURFACE_BUTTONS) begin
					col = (code - 1) / 3;
					row = (code - 1) % 3;
					if (row == 1) begin
						// solo buttons behave as radio buttons
						for (int c = 0; c < SURFACE_COLUMNS; c++) begin
							if (btn_lit[c * 3 + 1] != (c == col)) begin
								btn_lit[c * 3 + 1] = (c == col);
								queue_led(c * 3 + 1);
							end
						end
					end else begin
						btn_lit[col * 3 + row] = ~btn_lit[col * 3 + row];
						queue_led(col * 3 + row);
					end
				end else if (code == mmsh_pkg::NOTE_RESET) begin
					queue_result(mmsh_pkg::RES_RESET, 0, 1'b0, 0, 0, 0);
				end
			end
			clear_assembly();
		end

		// mark the final result of this byte
		if (expected_results.size() > base) begin
			tail = expected_results.pop_back();
			tail.last = 1'b1;
			expected_results.push_back(tail);
		end
	endtask

	// stimulus helpers
	task automatic push_byte(input logic [7:0] b);
		pending_bytes.push_back(b);
	endtask

	task automatic push_msg(input logic [7:0] status, input logic [7:0] d1,
			input logic [7:0] d2);
		push_byte(status);
		push_byte(d1);
		push_byte(d2);
	endtask

	function automatic logic [3:0] rand_chan();
		return 4'($urandom_range(0, 15));
	endfunction

	function automatic logic [7:0] slider_code(input int p);
		if (p < 16)
			return 8'(mmsh_pkg::SLIDER_LO_FIRST + p);
		return 8'(mmsh_pkg::SLIDER_HI_FIRST + p - 16);
	endfunction

	// something that must leave the chain alone
	task automatic push_filler();
		case ($urandom_range(0, 3))
			0: push_msg({mmsh_pkg::MSG_CC, rand_chan()}, 8'($urandom_range(0, 15)),
				8'($urandom_range(0, 127)));
			1: push_msg({mmsh_pkg::MSG_CC, rand_chan()}, 8'($urandom_range(63, 127)),
				8'($urandom_range(0, 127)));
			2: push_msg({mmsh_pkg::MSG_NOTE, rand_chan()}, 8'($urandom_range(25, 127)),
				8'($urandom_range(0, 127)));
			default: push_byte(8'($urandom_range(mmsh_pkg::STATUS_SYS, 255)));
		endcase
	endtask

	// slider updates in send-all order from one position to another
	task automatic push_chain(input int first_pos, input int stop_pos);
		for (int p = first_pos; p <= stop_pos; p++) begin
			if ($urandom_range(0, 9) == 0)
				push_filler();
			push_msg({mmsh_pkg::MSG_CC, rand_chan()}, slider_code(p),
				8'($urandom_range(0, 127)));
		end
	endtask

	// driver: offers pending bytes, predicts each one as its transaction happens
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			rx_byte    <= 8'h00;
			src_gap    <= 0;
			n_accepted <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_byte(rx_byte);
				n_accepted <= n_accepted + 1;
			end
			// hold the byte until its transaction, else idle or offer the next one
			if (!in_valid || in_ready) begin
				if (src_gap > 0) begin
					src_gap  <= src_gap - 1;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					rx_byte  <= pending_bytes.pop_front();
					in_valid <= 1'b1;
					src_gap  <= pick_gap(src_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each result transaction against the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result kind %0d code %0d", kind,
						led_code));
				end else begin
					next_result = expected_results.pop_front();
					if (kind !== next_result.kind)
						report_mismatch($sformatf("kind %0d, expected %0d", kind,
							next_result.kind));
					if (led_code !== next_result.led_code)
						report_mismatch($sformatf("led_code %0d, expected %0d", led_code,
							next_result.led_code));
					if (led_lit !== next_result.led_lit)
						report_mismatch($sformatf("led_lit %0d, expected %0d", led_lit,
							next_result.led_lit));
					if (slider_column !== next_result.col)
						report_mismatch($sformatf("slider_column %0d, expected %0d",
							slider_column, next_result.col));
					if (slider_row !== next_result.row)
						report_mismatch($sformatf("slider_row %0d, expected %0d",
							slider_row, next_result.row));
					if (slider_level !== next_result.level)
						report_mismatch($sformatf("slider_level %0d, expected %0d",
							slider_level, next_result.level));
					if (last !== next_result.last)
						report_mismatch($sformatf("last %0d, expected %0d", last,
							next_result.last));
				end
				n_results++;
				sink_gap = pick_gap(sink_calm);
			end else if (sink_gap > 0) begin
				sink_gap = sink_gap - 1;
			end
			out_ready <= (sink_gap == 0) && !sink_hold;
		end
	end

	// receiver hold-off, twice, so the block backs up and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sink_hold  <= 1'b0;
			hold_left  <= 0;
			holds_done <= 2'd0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			sink_hold <= (hold_left > 1);
		end else if ((holds_done == 2'd0 && n_accepted >= 40) ||
				(holds_done == 2'd1 && n_accepted >= 160)) begin
			sink_hold  <= 1'b1;
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 2'd1;
		end
	end

	initial begin
		int s;
		int e;
		logic [3:0] other;

		clear_assembly();
		btn_lit  = '0;
		chain_at = mmsh_pkg::NO_CHAIN;

		// send-all sync with no solo on yet: column 0 takes the solo
		push_chain(0, 32);

		// directed corners
		push_byte(8'h05);                                   // data with no status
		push_byte(mmsh_pkg::STATUS_SYS);
		push_byte({mmsh_pkg::MSG_PROGRAM, 4'h5});           // handled on its status byte
		push_byte(8'h22);                                   // so this data is ignored
		push_byte({mmsh_pkg::MSG_PRESSURE, 4'h3});
		push_byte(8'h7F);
		push_msg({mmsh_pkg::MSG_NOTE, 4'h0}, 8'h01, 8'h00); // mute toggle, zero velocity
		push_msg({mmsh_pkg::MSG_NOTE, 4'hF}, 8'h05, 8'h7F); // solo moves to column 1
		push_msg({mmsh_pkg::MSG_NOTE, 4'h0}, 8'h05, 8'h40); // active solo again, no result
		push_msg({mmsh_pkg::MSG_NOTE, 4'h0}, 8'h18, 8'h7F); // highest button code
		push_msg({mmsh_pkg::MSG_NOTE, 4'h0}, {1'b0, mmsh_pkg::NOTE_RESET}, 8'h00);
		push_msg({mmsh_pkg::MSG_NOTE, 4'h0}, 8'h7F, 8'h01); // unknown note
		push_msg({mmsh_pkg::MSG_NOTE, 4'h0}, 8'h00, 8'h10); // button code zero
		push_msg({mmsh_pkg::MSG_CC, 4'h0}, 8'h07, 8'h40);   // control that is no slider
		// slider, lowest level
		push_msg({mmsh_pkg::MSG_CC, 4'h0}, {1'b0, mmsh_pkg::SLIDER_LO_FIRST}, 8'h00);
		// master, out of order
		push_msg({mmsh_pkg::MSG_CC, 4'hF}, {1'b0, mmsh_pkg::SLIDER_HI_LAST}, 8'h7F);
		push_msg({MSG_PITCH_BEND, 4'h0}, 8'h01, 8'h02);    // other status dropped
		push_msg({mmsh_pkg::MSG_CC, 4'h0}, 8'h11, 8'hF8);   // system byte mid message
		push_byte(8'h55);
		push_byte(8'hFF);

		// random part, mostly well-formed messages
		while (pending_bytes.size() < ITEM_TARGET) begin
			case ($urandom_range(0, 99)) inside
				[0:7]: push_chain(0, 32);
				[8:27]: begin
					s = $urandom_range(0, 30);
					e = s + $urandom_range(2, 10);
					push_chain(s, (e > 32) ? 32 : e);
					if ($urandom_range(0, 1) == 0)
						push_msg({mmsh_pkg::MSG_CC, rand_chan()},
							slider_code($urandom_range(0, 32)), 8'($urandom_range(0, 127)));
				end
				[28:62]: begin
					if ($urandom_range(0, 9) != 0)
						push_msg({mmsh_pkg::MSG_NOTE, rand_chan()}, 8'($urandom_range(1, 25)),
							8'($urandom_range(0, 127)));
					else
						push_msg({mmsh_pkg::MSG_NOTE, rand_chan()}, 8'($urandom_range(0, 127)),
							8'($urandom_range(0, 127)));
				end
				[63:72]: push_msg({mmsh_pkg::MSG_CC, rand_chan()},
					slider_code($urandom_range(0, 32)), 8'($urandom_range(0, 127)));
				[73:80]: begin
					repeat ($urandom_range(1, 4))
						push_byte(8'($urandom_range(0, 255)));
				end
				[81:88]: begin
					case ($urandom_range(0, 4))
						0: other = MSG_NOTE_OFF;
						1: other = MSG_POLY_PRESSURE;
						2: other = MSG_PITCH_BEND;
						3: other = mmsh_pkg::MSG_PROGRAM;
						default: other = mmsh_pkg::MSG_PRESSURE;
					endcase
					push_byte({other, rand_chan()});
					push_byte(8'($urandom_range(0, 127)));
					if (other != mmsh_pkg::MSG_PROGRAM && other != mmsh_pkg::MSG_PRESSURE)
						push_byte(8'($urandom_range(0, 127)));
				end
				[89:95]: begin
					push_byte($urandom_range(0, 1) ? {mmsh_pkg::MSG_CC, rand_chan()} :
						{mmsh_pkg::MSG_NOTE, rand_chan()});
					push_byte(8'($urandom_range(0, 127)));
					push_byte(8'($urandom_range(mmsh_pkg::STATUS_SYS, 255)));
					push_byte(8'($urandom_range(0, 127)));
				end
				default: begin
					// status replaced while the message is half built
					push_byte({mmsh_pkg::MSG_CC, rand_chan()});
					push_byte(8'($urandom_range(0, 127)));
					push_byte({mmsh_pkg::MSG_NOTE, rand_chan()});
					push_byte(8'($urandom_range(0, 127)));
				end
			endcase
		end
		n_total = pending_bytes.size();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// every byte taken, every result seen, then a quiet tail
		while (n_accepted < n_total)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog
	initial begin
		#(CLK_PERIOD * 1000000);
		$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire

// ===== midi_mixer_surface_handler.f =====
hw/rtl/mmsh_pkg.sv
hw/rtl/mmsh_parser.sv
hw/rtl/midi_mixer_surface_handler.sv
verif/tb_midi_mixer_surface_handler.sv
